[src/gvr_pkg.sv]
// Shared types and codes for the grid visibility raycaster.
package gvr_pkg;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_CAST   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_COL_OUT = 2'd1;
  localparam logic [1:0] ST_ROW_OUT = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int CW = 12;

  // unit step for coordinate counters
  localparam logic signed [CW-1:0] ONE = CW'(1);

  // control between the sequencer and the line stepper
  typedef struct packed {
    logic           start;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
  } line_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } line_sts_t;

endpackage

[src/grid_visibility_raycaster_top.sv]
// Top level of the grid visibility raycaster: sequencer, maps and ports.
// After reset the block clears both maps, one cell per cycle, and stalls its input until
// every cell is clear. A write or read goes from its accept in S_IDLE straight to its
// result in S_OUT. A cast scans every position of the (2r+1) square: an interior
// position only advances the scan, and a perimeter position launches a line on the
// shared Bresenham stepper (start, probe and test per cell, done, advance). There are 8r
// such lines of up to r+1 cells each. A stalled result holds in S_OUT until out_stall
// is released.
module grid_visibility_raycaster_top #(
  parameter int MAX_SIDE   = 64,
  parameter int MAX_RADIUS = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic signed [7:0] in_pos_x,
  input  logic signed [7:0] in_pos_y,
  input  logic [4:0] in_radius,
  input  logic       in_wall_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic       out_seen_out,
  output logic       out_wall_out,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int CW = gvr_pkg::CW;
  localparam int AW = $clog2(MAX_SIDE);
  localparam int IW = 2 * AW;
  localparam int ND = 1 << IW;
  localparam int SW = $clog2(MAX_SIDE + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LINE  = 6'b000100,
    S_WAIT  = 6'b001000,
    S_NEXT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic wall_mem [ND];
  logic seen_mem [ND];
  logic [IW-1:0] clr_r;
  logic wall_q_r, seen_q_r, pr_ok_r, rd_ok_r;
  logic clearing, wr_ok;
  logic wall_we, wall_wd, wall_re, seen_we, seen_wd, seen_re;
  logic [IW-1:0] wall_wa, wall_ra, seen_wa;
  logic [6:0] gw_r, gh_r;
  logic [SW-1:0] ew, eh;
  logic [1:0] status_r;
  logic signed [CW-1:0] cx_r, cy_r, r_r, i_r, j_r;
  logic [4:0] rad_sat;
  gvr_pkg::line_cmd_t cmd;
  gvr_pkg::line_sts_t sts;
  logic probe_vld, probe_stop;
  logic signed [CW-1:0] probe_x, probe_y;

  always_comb begin
    ew = (int'(gw_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(gw_r);
    eh = (int'(gh_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(gh_r);
    rad_sat = (int'(in_radius) > MAX_RADIUS) ? 5'(MAX_RADIUS) : in_radius;
  end

  function automatic logic [1:0] loc(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y,
                                     input logic [SW-1:0] w,
                                     input logic [SW-1:0] h);
    logic [1:0] s;
    s = gvr_pkg::ST_OK;
    if (x < 0 || x >= $signed({1'b0, CW'(w)})) s = gvr_pkg::ST_COL_OUT;
    else if (y < 0 || y >= $signed({1'b0, CW'(h)})) s = gvr_pkg::ST_ROW_OUT;
    return s;
  endfunction

  logic [1:0] in_loc, pr_loc;
  logic [AW-1:0] in_ax, in_ay, pr_ax, pr_ay;
  logic [IW-1:0] in_idx, pr_idx;
  assign in_loc = loc(CW'(in_pos_x), CW'(in_pos_y), ew, eh);
  assign pr_loc = loc(probe_x, probe_y, ew, eh);
  assign in_ax = in_pos_x[AW-1:0];
  assign in_ay = in_pos_y[AW-1:0];
  assign pr_ax = probe_x[AW-1:0];
  assign pr_ay = probe_y[AW-1:0];
  assign in_idx = {in_ay, in_ax};
  assign pr_idx = {pr_ay, pr_ax};
  // wall bit of the probed cell arrives in the cycle after the probe
  assign probe_stop = pr_ok_r && wall_q_r;

  // square walk: i outer, j inner, lines only on the border
  logic on_edge, last_ij;
  assign on_edge = (i_r == cx_r - r_r) || (i_r == cx_r + r_r) ||
                   (j_r == cy_r - r_r) || (j_r == cy_r + r_r);
  assign last_ij = (i_r == cx_r + r_r) && (j_r == cy_r + r_r);

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.x0 = cx_r;
    cmd.y0 = cy_r;
    cmd.x1 = i_r;
    cmd.y1 = j_r;
    case (state_r)
      S_CLEAR: if (&clr_r) state_nxt = S_IDLE;
      S_IDLE: if (accept) state_nxt = (in_action == gvr_pkg::ACT_CAST) ? S_LINE : S_OUT;
      S_LINE: begin
        if (on_edge) begin
          cmd.start = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = last_ij ? S_OUT : S_NEXT;
        end
      end
      S_WAIT: if (sts.done) state_nxt = last_ij ? S_OUT : S_NEXT;
      S_NEXT: state_nxt = S_LINE;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // map ports: one write and one registered read per map and cycle
  always_comb begin
    clearing = (state_r == S_CLEAR);
    wr_ok = accept && in_action == gvr_pkg::ACT_WRITE && in_loc == gvr_pkg::ST_OK;
    wall_we = clearing || wr_ok;
    wall_wa = clearing ? clr_r : in_idx;
    wall_wd = !clearing && in_wall_in;
    wall_re = accept || probe_vld;
    wall_ra = probe_vld ? pr_idx : in_idx;
    seen_we = clearing || wr_ok || (probe_vld && pr_loc == gvr_pkg::ST_OK);
    seen_wa = clearing ? clr_r : (probe_vld ? pr_idx : in_idx);
    seen_wd = !clearing && probe_vld;
    seen_re = accept;
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_wa] <= wall_wd;
    if (wall_re) wall_q_r <= wall_mem[wall_ra];
  end

  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    if (seen_re) seen_q_r <= seen_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      gw_r <= 7'd64;
      gh_r <= 7'd64;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (cfg_we) begin
        if (cfg_index == gvr_pkg::CFG_WIDTH) gw_r <= cfg_data;
        else gh_r <= cfg_data;
      end
    end
    if (probe_vld) pr_ok_r <= (pr_loc == gvr_pkg::ST_OK);
    if (accept) begin
      status_r <= gvr_pkg::ST_OK;
      if (in_action == gvr_pkg::ACT_WRITE || in_action == gvr_pkg::ACT_READ)
        status_r <= in_loc;
      rd_ok_r <= (in_action == gvr_pkg::ACT_READ) && (in_loc == gvr_pkg::ST_OK);
      cx_r <= CW'(in_pos_x);
      cy_r <= CW'(in_pos_y);
      r_r  <= CW'(rad_sat);
      i_r  <= CW'(in_pos_x) - CW'(rad_sat);
      j_r  <= CW'(in_pos_y) - CW'(rad_sat);
    end else if (state_nxt == S_NEXT) begin
      if (j_r == cy_r + r_r) begin
        j_r <= cy_r - r_r;
        i_r <= i_r + gvr_pkg::ONE;
      end else begin
        j_r <= j_r + gvr_pkg::ONE;
      end
    end
  end

  gvr_line u_line (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .probe_vld(probe_vld), .probe_x(probe_x), .probe_y(probe_y),
    .probe_stop(probe_stop)
  );

  assign out_valid = (state_r == S_OUT);
  assign out_status = status_r;
  assign out_seen_out = rd_ok_r & seen_q_r;
  assign out_wall_out = rd_ok_r & wall_q_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept) else $error("accept while busy");
  a_line_only_cast: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> (state_r == S_WAIT)) else $error("stepper busy outside cast");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("result dropped");
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall) else $error("input open during clear");

endmodule

[src/gvr_line.sv]
// Bresenham line stepper: walks one line, probing and then testing each cell.
module gvr_line (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gvr_pkg::line_cmd_t       cmd,
  output gvr_pkg::line_sts_t       sts,
  // cell probe
  output logic                     probe_vld,
  output logic signed [gvr_pkg::CW-1:0] probe_x,
  output logic signed [gvr_pkg::CW-1:0] probe_y,
  input  logic                     probe_stop
);

  // probe presents the cell; the wall bit comes back registered for the test cycle
  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_PROBE = 3'b010,
    L_TEST = 3'b100
  } lstate_t;

  lstate_t state_r, state_nxt;
  logic signed [gvr_pkg::CW-1:0] x_r, y_r, x1_r, y1_r, dx_r, dy_r, err_r;
  logic signed [gvr_pkg::CW-1:0] x_nxt, y_nxt, dx_nxt, dy_nxt, err_nxt;
  logic sx_r, sy_r;
  logic done_nxt, done_r;
  logic signed [gvr_pkg::CW-1:0] adx, ady, e2;

  always_comb begin
    adx = (cmd.x1 > cmd.x0) ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1;
    ady = (cmd.y1 > cmd.y0) ? cmd.y1 - cmd.y0 : cmd.y0 - cmd.y1;
  end

  assign e2 = err_r;

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    err_nxt = err_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    done_nxt = 1'b0;
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          x_nxt = cmd.x0;
          y_nxt = cmd.y0;
          dx_nxt = adx;
          dy_nxt = ady;
          err_nxt = (adx > ady) ? (adx >>> 1) : -(ady >>> 1);
          state_nxt = L_PROBE;
        end
      end
      L_PROBE: begin
        state_nxt = L_TEST;
      end
      L_TEST: begin
        if (probe_stop || (x_r == x1_r && y_r == y1_r)) begin
          state_nxt = L_IDLE;
          done_nxt = 1'b1;
        end else begin
          if (e2 > -dx_r && e2 < dy_r) begin
            err_nxt = err_r - dy_r + dx_r;
          end else if (e2 > -dx_r) begin
            err_nxt = err_r - dy_r;
          end else if (e2 < dy_r) begin
            err_nxt = err_r + dx_r;
          end
          if (e2 > -dx_r) x_nxt = sx_r ? x_r + gvr_pkg::ONE : x_r - gvr_pkg::ONE;
          if (e2 < dy_r) y_nxt = sy_r ? y_r + gvr_pkg::ONE : y_r - gvr_pkg::ONE;
          state_nxt = L_PROBE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    err_r <= err_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    if (state_r == L_IDLE && cmd.start) begin
      x1_r <= cmd.x1;
      y1_r <= cmd.y1;
      sx_r <= cmd.x0 < cmd.x1;
      sy_r <= cmd.y0 < cmd.y1;
    end
  end

  assign probe_vld = (state_r == L_PROBE);
  assign probe_x = x_r;
  assign probe_y = y_r;
  assign sts.busy = (state_r != L_IDLE);
  assign sts.done = done_r;

endmodule
